// ===== sv/vertex_transform_perspective_divide_top_assert.svh =====
// Assertion macros shared by the checker of the vertex transform block.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_ASSERT_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define VTPD_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define VTPD_ASSERT_ANY(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/vtpd_pkg.sv =====
// Shared constants and types of the vertex transform and perspective divide block.
package vtpd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NUM_REGS = 8;
	localparam int REG_W = 64;
	localparam int IDX_W = 3;
	localparam int COORD_W = 32;
	localparam int PROD_W = 2 * COORD_W;
	localparam int SUM_W = PROD_W + 2;
	localparam int NQ_W = COORD_W + FRAC_BITS;
	localparam int LANE_LAT = 3;
	localparam int DIV_LAT = NQ_W + 2;
	localparam int PIPE_LAT = LANE_LAT + DIV_LAT + 1;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t sum;
		logic sat;
	} lane_res_t;

	typedef struct packed {
		coord_t quo;
		logic sat;
	} div_res_t;

endpackage

// ===== sv/vertex_transform_perspective_divide_top.sv =====
// Top level: matrix registers, four column lanes, three dividers and the merging stage.
// Throughput is one beat per cycle; the only limit is a stalled output beat.
// The whole pipeline advances together whenever the output register is free or taken.
// Reset clears the matrix to zero and empties the pipeline; data registers are not reset.
module vertex_transform_perspective_divide_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [vtpd_pkg::IDX_W-1:0] cfg_index,
	input logic [vtpd_pkg::REG_W-1:0] cfg_data,
	input logic point_valid,
	output logic point_stall,
	input vtpd_pkg::coord_t point_x,
	input vtpd_pkg::coord_t point_y,
	input vtpd_pkg::coord_t point_z,
	output logic result_valid,
	input logic result_stall,
	output vtpd_pkg::coord_t out_x,
	output vtpd_pkg::coord_t out_y,
	output vtpd_pkg::coord_t out_z,
	output logic w_was_zero,
	output logic saturated
);
	import vtpd_pkg::*;

	logic [REG_W-1:0] mat_q [NUM_REGS];
	logic [PIPE_LAT-1:0] vld_q;
	logic en;
	lane_res_t lane_res [4];
	div_res_t div_res [3];
	logic wz_s [DIV_LAT];
	logic sat_s [DIV_LAT];

	assign en = !result_valid || !result_stall;
	assign point_stall = !en;
	assign result_valid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				mat_q[i] <= '0;
			end
		end else if (cfg_we) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], point_valid};
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_lane
		vtpd_lane u_lane (
			.clk(clk),
			.en(en),
			.px(point_x),
			.py(point_y),
			.pz(point_z),
			.m0(mat_q[c/2][(c%2)*COORD_W +: COORD_W]),
			.m1(mat_q[2 + c/2][(c%2)*COORD_W +: COORD_W]),
			.m2(mat_q[4 + c/2][(c%2)*COORD_W +: COORD_W]),
			.m3(mat_q[6 + c/2][(c%2)*COORD_W +: COORD_W]),
			.res(lane_res[c])
		);
	end

	for (genvar c = 0; c < 3; c++) begin : g_div
		vtpd_div u_div (
			.clk(clk),
			.en(en),
			.s(lane_res[c].sum),
			.w(lane_res[3].sum),
			.res(div_res[c])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wz_s[0] <= (lane_res[3].sum == '0);
			sat_s[0] <= lane_res[0].sat | lane_res[1].sat | lane_res[2].sat | lane_res[3].sat;
			for (int k = 1; k < DIV_LAT; k++) begin
				wz_s[k] <= wz_s[k-1];
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_x <= div_res[0].quo;
			out_y <= div_res[1].quo;
			out_z <= div_res[2].quo;
			w_was_zero <= wz_s[DIV_LAT-1];
			saturated <= sat_s[DIV_LAT-1] | div_res[0].sat | div_res[1].sat | div_res[2].sat;
		end
	end

endmodule

// ===== sv/vtpd_lane.sv =====
// One column lane: three products, exact sum with translation, floor and saturation.
module vtpd_lane (
	input logic clk,
	input logic en,
	input vtpd_pkg::coord_t px,
	input vtpd_pkg::coord_t py,
	input vtpd_pkg::coord_t pz,
	input vtpd_pkg::coord_t m0,
	input vtpd_pkg::coord_t m1,
	input vtpd_pkg::coord_t m2,
	input vtpd_pkg::coord_t m3,
	output vtpd_pkg::lane_res_t res
);
	import vtpd_pkg::*;

	logic signed [PROD_W-1:0] p0_s1, p1_s1, p2_s1;
	coord_t t_s1;
	logic signed [SUM_W-1:0] tot_s2;
	logic signed [SUM_W-1:0] sh;
	logic ovf;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= PROD_W'(px) * PROD_W'(m0);
			p1_s1 <= PROD_W'(py) * PROD_W'(m1);
			p2_s1 <= PROD_W'(pz) * PROD_W'(m2);
			t_s1 <= m3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tot_s2 <= SUM_W'(p0_s1) + SUM_W'(p1_s1) + SUM_W'(p2_s1)
				+ (SUM_W'(t_s1) <<< FRAC_BITS);
		end
	end

	assign sh = tot_s2 >>> FRAC_BITS;
	assign ovf = !((&sh[SUM_W-1:COORD_W-1]) || !(|sh[SUM_W-1:COORD_W-1]));

	always_ff @(posedge clk) begin
		if (en) begin
			res.sat <= ovf;
			if (ovf) begin
				res.sum <= sh[SUM_W-1] ? COORD_MIN : COORD_MAX;
			end else begin
				res.sum <= sh[COORD_W-1:0];
			end
		end
	end

endmodule

// ===== sv/vtpd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sign and saturation.
module vtpd_div (
	input logic clk,
	input logic en,
	input vtpd_pkg::coord_t s,
	input vtpd_pkg::coord_t w,
	output vtpd_pkg::div_res_t res
);
	import vtpd_pkg::*;

	logic [COORD_W-1:0] rem_s [NQ_W+1];
	logic [NQ_W-1:0] nq_s [NQ_W+1];
	logic [COORD_W-1:0] d_s [NQ_W+1];
	logic neg_s [NQ_W+1];
	logic wz_s [NQ_W+1];
	coord_t sv_s [NQ_W+1];
	logic [NQ_W-1:0] q;
	logic [COORD_W-1:0] nmag, dmag;

	assign nmag = s[COORD_W-1] ? COORD_W'(-s) : COORD_W'(s);
	assign dmag = w[COORD_W-1] ? COORD_W'(-w) : COORD_W'(w);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			nq_s[0] <= {nmag, {FRAC_BITS{1'b0}}};
			d_s[0] <= dmag;
			neg_s[0] <= s[COORD_W-1] ^ w[COORD_W-1];
			wz_s[0] <= (w == '0);
			sv_s[0] <= s;
		end
	end

	for (genvar k = 0; k < NQ_W; k++) begin : g_stage
		logic [COORD_W:0] trial;
		logic ge;
		assign trial = {rem_s[k], nq_s[k][NQ_W-1]};
		assign ge = trial >= {1'b0, d_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? COORD_W'(trial - {1'b0, d_s[k]}) : trial[COORD_W-1:0];
				nq_s[k+1] <= {nq_s[k][NQ_W-2:0], ge};
				d_s[k+1] <= d_s[k];
				neg_s[k+1] <= neg_s[k];
				wz_s[k+1] <= wz_s[k];
				sv_s[k+1] <= sv_s[k];
			end
		end
	end

	assign q = nq_s[NQ_W];

	always_ff @(posedge clk) begin
		if (en) begin
			if (wz_s[NQ_W]) begin
				res.quo <= sv_s[NQ_W];
				res.sat <= 1'b0;
			end else if (neg_s[NQ_W]) begin
				if (q > NQ_W'(COORD_MIN[COORD_W-1:0])) begin
					res.quo <= COORD_MIN;
					res.sat <= 1'b1;
				end else begin
					res.quo <= -q[COORD_W-1:0];
					res.sat <= 1'b0;
				end
			end else begin
				if (q > NQ_W'(COORD_MAX[COORD_W-1:0])) begin
					res.quo <= COORD_MAX;
					res.sat <= 1'b1;
				end else begin
					res.quo <= q[COORD_W-1:0];
					res.sat <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== sv/vtpd_checker.sv =====
// Port-level checker of the vertex transform block and its bind statement.
`include "vertex_transform_perspective_divide_top_assert.svh"

module vtpd_checker (
	input logic clk,
	input logic arst_n,
	input logic point_stall,
	input logic result_valid,
	input logic result_stall,
	input vtpd_pkg::coord_t out_x,
	input vtpd_pkg::coord_t out_y,
	input vtpd_pkg::coord_t out_z,
	input logic w_was_zero,
	input logic saturated
);
	import vtpd_pkg::*;

	`VTPD_ASSERT_ANY(a_no_beat_in_reset, !arst_n |-> !result_valid, "result beat during reset")
	`VTPD_ASSERT_CLK(a_stall_only_when_blocked, point_stall |-> (result_valid && result_stall), "input stalled while output is free")
	`VTPD_ASSERT_CLK(a_taken_frees_input, (result_valid && !result_stall) |-> !point_stall, "input stalled while output beat is taken")
	`VTPD_ASSERT_CLK(a_out_hold, (result_valid && result_stall) |=> (result_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(w_was_zero) && $stable(saturated)), "stalled result beat changed")

endmodule

bind vertex_transform_perspective_divide_top vtpd_checker u_vtpd_checker (.*);

// ===== test/vertex_transform_perspective_divide_top_tb.sv =====
// Self-checking testbench for the vertex transform and perspective divide block.
`timescale 1ns / 1ps

module vertex_transform_perspective_divide_top_tb;
	import vtpd_pkg::*;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		logic wz;
		logic sat;
	} vertex_t;

	typedef enum int {
		MAT_RANDOM,
		MAT_SMALL,
		MAT_AFFINE,
		MAT_PERSPECTIVE,
		MAT_EXTREME,
		MAT_NO_W,
		MAT_KINDS
	} mat_kind_e;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_data;
	logic point_valid;
	logic point_stall;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;
	logic result_valid;
	logic result_stall;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	logic w_was_zero;
	logic saturated;

	coord_t matrix[4][4];
	point_t pending_points[$];
	vertex_t expected_vertices[$];
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int wz_seen = 0;
	int sat_seen = 0;
	int send_gap = 0;
	bit point_taken = 0;
	bit hold_request = 0;
	int hold_count = 0;
	int recv_gap = 0;

	vertex_transform_perspective_divide_top dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic coord_t clamp(input logic signed [95:0] v, inout logic flag);
		if (v > 96'sd2147483647) begin
			flag = 1'b1;
			return COORD_MAX;
		end
		if (v < -96'sd2147483648) begin
			flag = 1'b1;
			return COORD_MIN;
		end
		return coord_t'(v);
	endfunction

	function automatic vertex_t transform_point(input point_t p);
		logic signed [95:0] acc;
		logic signed [95:0] num;
		coord_t s[4];
		coord_t q[3];
		logic sat;
		vertex_t r;
		sat = 1'b0;
		for (int c = 0; c < 4; c++) begin
			acc = p.x * matrix[0][c] + p.y * matrix[1][c] + p.z * matrix[2][c];
			acc = (acc >>> FRAC_BITS) + matrix[3][c];
			s[c] = clamp(acc, sat);
		end
		r.wz = (s[3] == 0);
		for (int c = 0; c < 3; c++) begin
			if (r.wz) begin
				q[c] = s[c];
			end else begin
				num = s[c];
				num = num <<< FRAC_BITS;
				acc = s[3];
				q[c] = clamp(num / acc, sat);
			end
		end
		r.x = q[0];
		r.y = q[1];
		r.z = q[2];
		r.sat = sat;
		return r;
	endfunction

	function automatic coord_t rand_coord(input int kind);
		case (kind)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 1) ? COORD_MAX : COORD_MIN);
			2: return coord_t'(int'($urandom_range(0, 20 << FRAC_BITS)) - (10 << FRAC_BITS));
			default: return coord_t'(int'($urandom_range(0, 64)) - 32);
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		int k;
		k = $urandom_range(0, 9);
		k = (k < 3) ? 0 : (k < 4) ? 1 : (k < 8) ? 2 : 3;
		p.x = rand_coord(k);
		p.y = rand_coord($urandom_range(0, 9) < 7 ? k : $urandom_range(0, 3));
		p.z = rand_coord(k);
		return p;
	endfunction

	task automatic drain();
		wait (pending_points.size() == 0 && !point_valid && expected_vertices.size() == 0);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic load_matrix(input mat_kind_e kind);
		coord_t m[4][4];
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				case (kind)
					MAT_RANDOM: m[r][c] = coord_t'($urandom);
					MAT_SMALL: m[r][c] = rand_coord(2);
					MAT_EXTREME: m[r][c] = rand_coord($urandom_range(0, 1));
					default: m[r][c] = (r == c) ? coord_t'(1 << FRAC_BITS) : rand_coord(3);
				endcase
			end
		end
		if (kind == MAT_AFFINE) begin
			for (int r = 0; r < 3; r++) m[r][3] = '0;
			m[3][3] = 1 << FRAC_BITS;
			for (int c = 0; c < 3; c++) m[3][c] = rand_coord(2);
		end
		if (kind == MAT_PERSPECTIVE) begin
			m[0][3] = '0;
			m[1][3] = '0;
			m[2][3] = coord_t'($urandom_range(0, 1) ? -(1 << FRAC_BITS) : (1 << FRAC_BITS));
			m[3][3] = rand_coord(3);
		end
		if (kind == MAT_NO_W) begin
			for (int r = 0; r < 4; r++) m[r][3] = '0;
		end
		for (int i = 0; i < NUM_REGS; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data <= {m[i >> 1][((i & 1) << 1) + 1], m[i >> 1][(i & 1) << 1]};
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		matrix = m;
	endtask

	task automatic add_point(input coord_t x, input coord_t y, input coord_t z);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		pending_points.push_back(p);
	endtask

	// Sender: drops a point once it has been taken, then idles or offers the next one.
	always @(negedge clk) begin
		if (!point_valid || point_taken) begin
			point_taken = 0;
			if (send_gap > 0) begin
				send_gap--;
				point_valid <= 1'b0;
			end else if (pending_points.size() > 0) begin
				point_t p;
				p = pending_points.pop_front();
				point_valid <= 1'b1;
				point_x <= p.x;
				point_y <= p.y;
				point_z <= p.z;
				if (!hold_request && hold_count == 0)
					send_gap = ($urandom_range(0, 99) < 50) ? 0 :
						($urandom_range(0, 99) < 92) ? $urandom_range(1, 3) :
						$urandom_range(10, 60);
			end else begin
				point_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_count > 0) begin
			hold_count--;
			result_stall <= 1'b1;
		end else if (hold_request) begin
			hold_request = 0;
			hold_count = 300;
			result_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
			if ($urandom_range(0, 99) < 25)
				recv_gap = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) :
					$urandom_range(10, 50);
		end
	end

	always @(posedge clk) begin
		if (arst_n && point_valid && !point_stall) begin
			point_t p;
			p.x = point_x;
			p.y = point_y;
			p.z = point_z;
			expected_vertices.push_back(transform_point(p));
			point_taken = 1;
			beats_in++;
		end
		if (arst_n && result_valid && !result_stall) begin
			vertex_t e;
			beats_out++;
			if (expected_vertices.size() == 0) begin
				$error("result beat with no point outstanding");
				errors++;
			end else begin
				e = expected_vertices.pop_front();
				if (w_was_zero) wz_seen++;
				if (saturated) sat_seen++;
				if (out_x !== e.x) begin
					$error("out_x expected %0d got %0d", e.x, out_x);
					errors++;
				end
				if (out_y !== e.y) begin
					$error("out_y expected %0d got %0d", e.y, out_y);
					errors++;
				end
				if (out_z !== e.z) begin
					$error("out_z expected %0d got %0d", e.z, out_z);
					errors++;
				end
				if (w_was_zero !== e.wz) begin
					$error("w_was_zero expected %0b got %0b", e.wz, w_was_zero);
					errors++;
				end
				if (saturated !== e.sat) begin
					$error("saturated expected %0b got %0b", e.sat, saturated);
					errors++;
				end
			end
		end
	end

	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		point_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		result_stall = 1'b0;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				matrix[r][c] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The reset matrix gives zero w for every point.
		add_point(COORD_MAX, COORD_MIN, 32'sd0);
		add_point(32'sd1 << FRAC_BITS, -32'sd1, 32'sd12345);
		drain();

		load_matrix(MAT_PERSPECTIVE);
		add_point(COORD_MAX, COORD_MAX, COORD_MAX);
		add_point(COORD_MIN, COORD_MIN, COORD_MIN);
		add_point(32'sd0, 32'sd0, 32'sd0);
		add_point(-32'sd1, -32'sd1, -32'sd1);
		add_point(32'sd1 << FRAC_BITS, 32'sd2 << FRAC_BITS, 32'sd1 << FRAC_BITS);
		// With z chosen so that z times the w column cancels the w offset, w is zero.
		add_point(32'sd5 << FRAC_BITS, 32'sd7, (matrix[2][3] > 0) ? -matrix[3][3] : matrix[3][3]);
		drain();

		load_matrix(MAT_EXTREME);
		add_point(COORD_MAX, COORD_MIN, COORD_MAX);
		add_point(COORD_MIN, COORD_MAX, COORD_MIN);
		add_point(32'sd1, 32'sd0, -32'sd1);
		add_point(32'sd0, 32'sd0, 32'sd0);
		drain();

		load_matrix(MAT_NO_W);
		add_point(COORD_MAX, 32'sd3, COORD_MIN);
		add_point(32'sd100, -32'sd100, 32'sd0);
		drain();

		load_matrix(MAT_AFFINE);
		add_point(32'sd1 << FRAC_BITS, -32'sd1 << FRAC_BITS, 32'sd0);
		add_point(COORD_MAX, 32'sd0, 32'sd0);
		drain();

		for (phase = 0; phase < 10; phase++) begin
			load_matrix(mat_kind_e'((phase < MAT_KINDS) ? phase :
				$urandom_range(0, MAT_KINDS - 1)));
			if (phase == 2) begin
				hold_request = 1;
				send_gap = 0;
			end
			for (int i = 0; i < 85; i++) begin
				point_t p;
				p = rand_point();
				add_point(p.x, p.y, p.z);
			end
			if (phase == 4) begin
				wait (pending_points.size() == 0 && !point_valid &&
					expected_vertices.size() == 0);
			end
			for (int i = 0; i < 85; i++) begin
				point_t p;
				p = rand_point();
				add_point(p.x, p.y, p.z);
			end
			drain();
		end

		$display("Sent %0d points and checked %0d vertices over 15 matrix settings.",
			beats_in, beats_out);
		$display("Vertices with zero w: %0d, with clamping: %0d.", wz_seen, sat_seen);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
